// ===== rtl/dkrm_pkg.sv =====
// Shared types, sizes and the reciprocal table for the difference-keying
// rolling-mean block. No dependencies; every other rtl file imports this package.
`timescale 1ns / 1ps

package dkrm_pkg;

  localparam int HISTORY    = 10;
  localparam int MAX_PIXELS = 65536;

  // The index field is 16 bits wide, so no more than 65536 entries are reachable.
  localparam int MEM_PIX    = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;
  localparam int PIX_AW     = (MEM_PIX > 1) ? $clog2(MEM_PIX) : 1;
  localparam int RING_DEPTH = HISTORY * MEM_PIX;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SLOT_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int NFR_W      = $clog2(HISTORY + 1);

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int IDX_W      = 16;
  localparam int SUM_W      = 12;

  // Mean by reciprocal: q' = (sum * ceil(2^16 / n)) >> 16 is floor(sum / n) or one more.
  localparam int RECIP_W    = 17;
  localparam int RECIP_SH   = 16;
  localparam int PROD_W     = SUM_W + RECIP_W;
  localparam int QP_W       = PROD_W - RECIP_SH;
  localparam int REM_W      = SUM_W + 3;

  // Register stages in one channel lane.
  localparam int LANE_STAGES = 5;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [CH_W-1:0] THR_RESET = 8'd15;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  red;
    logic             last_in_frame;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
    logic            foreground;
  } pix_out_t;

  // Request from the top level to the history store, one per accepted pixel.
  typedef struct packed {
    logic                         valid;
    logic [IDX_W-1:0]             idx;
    logic [NUM_CH-1:0][CH_W-1:0]  px;
    logic [NFR_W-1:0]             n;
    logic [SLOT_W-1:0]            slot;
  } st_req_t;

  // What one channel lane needs to form its mean and compare.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  px;
    logic [NFR_W-1:0] n;
    logic             self_mean;
  } lane_in_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [NFR_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (32'(n))
      1:       m = 17'd65536;
      2:       m = 17'd32768;
      3:       m = 17'd21846;
      4:       m = 17'd16384;
      5:       m = 17'd13108;
      6:       m = 17'd10923;
      7:       m = 17'd9363;
      8:       m = 17'd8192;
      9:       m = 17'd7282;
      10:      m = 17'd6554;
      11:      m = 17'd5958;
      12:      m = 17'd5462;
      13:      m = 17'd5042;
      14:      m = 17'd4682;
      15:      m = 17'd4370;
      16:      m = 17'd4096;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/dkrm_store.sv =====
// Per-pixel history ring and running channel sums, with read-modify-write.
// Depends on dkrm_pkg; feeds the channel lanes one pixel per cycle.
`timescale 1ns / 1ps

module dkrm_store import dkrm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  st_req_t                  req,
  output logic                     s1_valid,
  output lane_in_t [NUM_CH-1:0]    lane_in
);

  logic [NUM_CH-1:0][SUM_W-1:0] sum_mem  [MEM_PIX];
  logic [NUM_CH-1:0][CH_W-1:0]  ring_mem [RING_DEPTH];

  logic [PIX_AW-1:0]            req_paddr;
  logic [RING_AW-1:0]           req_raddr;
  logic                         req_inr;

  logic                         s1_valid_r;
  logic                         s1_inr_r;
  logic [PIX_AW-1:0]            s1_paddr_r;
  logic [RING_AW-1:0]           s1_raddr_r;
  logic [NUM_CH-1:0][CH_W-1:0]  s1_px_r;
  logic [NFR_W-1:0]             s1_n_r;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_rd_r;
  logic [NUM_CH-1:0][CH_W-1:0]  ring_rd_r;

  logic                         fwd_en_r;
  logic [PIX_AW-1:0]            fwd_paddr_r;
  logic [RING_AW-1:0]           fwd_raddr_r;
  logic [NUM_CH-1:0][SUM_W-1:0] fwd_sum_r;
  logic [NUM_CH-1:0][CH_W-1:0]  fwd_ring_r;

  logic                         wr_en;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_cur;
  logic [NUM_CH-1:0][CH_W-1:0]  ring_old;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_nxt;

  assign req_paddr = req.idx[PIX_AW-1:0];
  assign req_raddr = RING_AW'(req.slot) * RING_AW'(MEM_PIX) + RING_AW'(req_paddr);
  assign req_inr   = (32'(req.idx) < MAX_PIXELS);
  assign wr_en     = s1_valid_r && s1_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_en_r   <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
      fwd_en_r   <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_inr_r   <= req_inr;
      s1_paddr_r <= req_paddr;
      s1_raddr_r <= req_raddr;
      s1_px_r    <= req.px;
      s1_n_r     <= req.n;
      sum_rd_r   <= sum_mem[req_paddr];
      ring_rd_r  <= ring_mem[req_raddr];
    end
    fwd_paddr_r <= s1_paddr_r;
    fwd_raddr_r <= s1_raddr_r;
    fwd_sum_r   <= sum_nxt;
    fwd_ring_r  <= s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sum_mem[s1_paddr_r]  <= sum_nxt;
      ring_mem[s1_raddr_r] <= s1_px_r;
    end
  end

  // The write made at the previous edge was not yet visible to this pixel's read.
  always_comb begin
    sum_cur  = (fwd_en_r && fwd_paddr_r == s1_paddr_r) ? fwd_sum_r  : sum_rd_r;
    ring_old = (fwd_en_r && fwd_raddr_r == s1_raddr_r) ? fwd_ring_r : ring_rd_r;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (s1_n_r == '0) begin
        sum_nxt[ch] = SUM_W'(s1_px_r[ch]);
      end else if (32'(s1_n_r) >= HISTORY) begin
        sum_nxt[ch] = sum_cur[ch] + SUM_W'(s1_px_r[ch]) - SUM_W'(ring_old[ch]);
      end else begin
        sum_nxt[ch] = sum_cur[ch] + SUM_W'(s1_px_r[ch]);
      end
      lane_in[ch].sum       = sum_cur[ch];
      lane_in[ch].px        = s1_px_r[ch];
      lane_in[ch].n         = s1_n_r;
      lane_in[ch].self_mean = !s1_inr_r || (s1_n_r == '0);
    end
  end

  assign s1_valid = s1_valid_r;

endmodule

// ===== rtl/dkrm_lane.sv =====
// One channel lane: rounded mean of the running sum, then the threshold compare.
// Depends on dkrm_pkg; five register stages, one pixel per cycle.
`timescale 1ns / 1ps

module dkrm_lane import dkrm_pkg::*; (
  input  logic            clk,
  input  lane_in_t        lin,
  input  logic [CH_W-1:0] thr,
  output logic            near,
  output logic [CH_W-1:0] px_out
);

  lane_in_t           a_r;

  logic [PROD_W-1:0]  b_prod_r;
  logic [SUM_W-1:0]   b_sum_r;
  logic [CH_W-1:0]    b_px_r;
  logic [NFR_W-1:0]   b_n_r;
  logic               b_self_r;

  logic [QP_W-1:0]    c_qp_r;
  logic [REM_W-1:0]   c_rem_r;
  logic [CH_W-1:0]    c_px_r;
  logic [NFR_W-1:0]   c_n_r;
  logic               c_self_r;

  logic [CH_W-1:0]    d_mean_r;
  logic [CH_W-1:0]    d_px_r;

  logic               e_near_r;
  logic [CH_W-1:0]    e_px_r;

  logic [QP_W-1:0]    qp_c;
  logic [REM_W-1:0]   rem_c;
  logic [QP_W-1:0]    q_d;
  logic [REM_W-1:0]   rm_d;
  logic [REM_W-1:0]   rm2_d;
  logic               up_d;
  logic [QP_W-1:0]    qr_d;
  logic [CH_W-1:0]    mean_nxt;
  logic [CH_W-1:0]    diff_e;

  assign qp_c  = b_prod_r[PROD_W-1:RECIP_SH];
  assign rem_c = REM_W'(b_sum_r) - REM_W'(qp_c) * REM_W'(b_n_r);

  // The estimate is at most one too large; a negative remainder undoes that.
  always_comb begin
    if (c_rem_r[REM_W-1]) begin
      q_d  = c_qp_r - QP_W'(1);
      rm_d = c_rem_r + REM_W'(c_n_r);
    end else begin
      q_d  = c_qp_r;
      rm_d = c_rem_r;
    end
    rm2_d = rm_d << 1;
    up_d  = (rm2_d > REM_W'(c_n_r)) || ((rm2_d == REM_W'(c_n_r)) && q_d[0]);
    qr_d  = q_d + QP_W'(up_d);
    if (c_self_r) begin
      mean_nxt = c_px_r;
    end else if (qr_d > QP_W'(255)) begin
      mean_nxt = 8'd255;
    end else begin
      mean_nxt = qr_d[CH_W-1:0];
    end
  end

  assign diff_e = (d_px_r > d_mean_r) ? (d_px_r - d_mean_r) : (d_mean_r - d_px_r);

  always_ff @(posedge clk) begin
    a_r      <= lin;

    b_prod_r <= PROD_W'(a_r.sum) * PROD_W'(recip(a_r.n));
    b_sum_r  <= a_r.sum;
    b_px_r   <= a_r.px;
    b_n_r    <= a_r.n;
    b_self_r <= a_r.self_mean;

    c_qp_r   <= qp_c;
    c_rem_r  <= rem_c;
    c_px_r   <= b_px_r;
    c_n_r    <= b_n_r;
    c_self_r <= b_self_r;

    d_mean_r <= mean_nxt;
    d_px_r   <= c_px_r;

    e_near_r <= (diff_e < thr);
    e_px_r   <= d_px_r;
  end

  assign near   = e_near_r;
  assign px_out = e_px_r;

endmodule

// ===== rtl/dkrm_merge.sv =====
// Merges the channel lanes' compare flags into a keyed pixel and buffers results.
// Depends on dkrm_pkg; drives the result channel from a small register queue.
`timescale 1ns / 1ps

module dkrm_merge import dkrm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [NUM_CH-1:0]           near,
  input  logic [NUM_CH-1:0][CH_W-1:0] px,
  input  logic                        out_stall,
  output logic                        out_valid,
  output pix_out_t                    out_data
);

  pix_out_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;
  logic              rd_en;
  logic              background;
  pix_out_t          entry;

  // A single channel close to its mean is enough to call the pixel background.
  assign background = |near;
  assign entry      = background ? pix_out_t'('0) : {px[0], px[1], px[2], 1'b1};

  assign out_valid = (fill_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];
  assign rd_en     = out_valid && !out_stall;

  always_comb begin
    case ({wr_en, rd_en})
      2'b10:   fill_nxt = fill_r + CNT_W'(1);
      2'b01:   fill_nxt = fill_r - CNT_W'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== rtl/difference_keying_rolling_mean_unit.sv =====
// Top level of the difference-keying background subtractor with rolling mean.
// Depends on dkrm_pkg, dkrm_store, dkrm_lane and dkrm_merge.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  pix_in_t  in_data
//   out_      output     out_valid/out_stall  pix_out_t out_data
//   cfg_      input      cfg_valid/cfg_ready  threshold cfg_data[7:0]
//
// One pixel is taken every cycle while in_stall is low; the store and lanes register it.
// The store does one read-modify-write per pixel per cycle on its sum and ring memories.
// Synchronous reset clears frame count, ring slot, threshold (15) and all queues;
// the memories are not cleared.
// Results queue in an 8-entry buffer; in_stall rises once 8 pixels are unclaimed.
`timescale 1ns / 1ps

module difference_keying_rolling_mean_unit import dkrm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output pix_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CH_W-1:0] cfg_data
);

  logic [CH_W-1:0]             thr_r;
  logic [NFR_W-1:0]            frames_r;
  logic [NFR_W-1:0]            frames_nxt;
  logic [SLOT_W-1:0]           slot_r;
  logic [SLOT_W-1:0]           slot_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [LANE_STAGES-1:0]      vld_r;

  logic                        in_acc;
  logic                        out_take;
  st_req_t                     req;
  logic                        s1_valid;
  lane_in_t [NUM_CH-1:0]       lane_in;
  logic [NUM_CH-1:0]           near;
  logic [NUM_CH-1:0][CH_W-1:0] lane_px;

  assign cfg_ready = 1'b1;
  assign in_stall  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_comb begin
    req.valid = in_acc;
    req.idx   = in_data.pixel_index;
    req.px    = {in_data.red, in_data.green, in_data.blue};
    req.n     = frames_r;
    req.slot  = slot_r;
  end

  // Frame bookkeeping moves at the transfer of the last pixel, so the next
  // pixel already sees the new frame count and ring slot.
  always_comb begin
    frames_nxt = frames_r;
    slot_nxt   = slot_r;
    if (in_acc && in_data.last_in_frame) begin
      slot_nxt = (slot_r == SLOT_W'(HISTORY - 1)) ? '0 : slot_r + SLOT_W'(1);
      if (32'(frames_r) < HISTORY) begin
        frames_nxt = frames_r + NFR_W'(1);
      end
    end
  end

  always_comb begin
    case ({in_acc, out_take})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      frames_r <= '0;
      slot_r   <= '0;
      cnt_r    <= '0;
      vld_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      frames_r <= frames_nxt;
      slot_r   <= slot_nxt;
      cnt_r    <= cnt_nxt;
      vld_r    <= {vld_r[LANE_STAGES-2:0], s1_valid};
    end
  end

  dkrm_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .s1_valid (s1_valid),
    .lane_in  (lane_in)
  );

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    dkrm_lane u_lane (
      .clk    (clk),
      .lin    (lane_in[ch]),
      .thr    (thr_r),
      .near   (near[ch]),
      .px_out (lane_px[ch])
    );
  end

  dkrm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (vld_r[LANE_STAGES-1]),
    .near      (near),
    .px        (lane_px),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_bg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.foreground |->
      out_data.out_blue == '0 && out_data.out_green == '0 && out_data.out_red == '0)
    else $error("background result carries nonzero channels");

  a_pipe_credit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({vld_r, s1_valid}) <= 32'(cnt_r))
    else $error("more pixels in flight than transfers outstanding");

  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result offered with no outstanding pixel");

  a_frames_sat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.last_in_frame && 32'(frames_r) == HISTORY |=> $stable(frames_r))
    else $error("frame count moved past its saturation point");
`endif

endmodule
